// File: hw/rtl/fdc_pkg.sv
// ---------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants for the floppy controller DMA register window.
// ---------------------------------------------------------------------------
package fdc_pkg;

    localparam int SECTOR_BYTES_DEF  = 512;
    localparam int MAX_SPT_DEF       = 11;
    localparam int IDX_W             = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 25;

    localparam logic [2:0] OP_WR_MODE  = 3'd0;
    localparam logic [2:0] OP_WR_ADDR  = 3'd1;
    localparam logic [2:0] OP_RD_ADDR  = 3'd2;
    localparam logic [2:0] OP_WR_DATA  = 3'd3;
    localparam logic [2:0] OP_RD_DATA  = 3'd4;
    localparam logic [2:0] OP_RD_DMAST = 3'd5;
    localparam logic [2:0] OP_WR_DRIVE = 3'd6;
    localparam logic [2:0] OP_TICK     = 3'd7;

    localparam logic [2:0] CFG_TRACKS   = 3'd0;
    localparam logic [2:0] CFG_SIDES    = 3'd1;
    localparam logic [2:0] CFG_SPT      = 3'd2;
    localparam logic [2:0] CFG_MEDIA    = 3'd3;
    localparam logic [2:0] CFG_MEMBYTES = 3'd4;
    localparam logic [2:0] CFG_IRQDLY   = 3'd5;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_RD    = 2'd1;
    localparam logic [1:0] KIND_WR    = 2'd2;
    localparam logic [1:0] KIND_IDREC = 2'd3;

    localparam logic [7:0] STATUS_RNF   = 8'h10;
    localparam logic [7:0] MAX_TRACK    = 8'd90;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  byte_select;
        logic [15:0] value;
        logic [15:0] cycles;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] disk_sector_index;
        logic [23:0] memory_address;
        logic [47:0] id_record;
        logic [15:0] read_data;
        logic        interrupt_line;
        logic        busy_flag;
        logic        last;
    } out_item_t;

endpackage

// File: hw/rtl/fdc_idx_unit.sv
// ---------------------------------------------------------------------------
// fdc_idx_unit
// Two-step linear sector index: (track*sides+side)*spt + sector - 1.
// ---------------------------------------------------------------------------
module fdc_idx_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [7:0]                  track,
    input  logic                        side,
    input  logic [1:0]                  side_count,
    input  logic [3:0]                  spt,
    input  logic [7:0]                  sector,
    output logic [fdc_pkg::IDX_W-1:0]   idx,
    output logic                        done
);
    logic [9:0]                 t1_reg;
    logic                       step_reg;
    logic [fdc_pkg::IDX_W-1:0]  idx_reg;
    logic                       done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= start;
            done_reg <= step_reg;
        end
        if (start)
            t1_reg <= {2'd0, track} * {8'd0, side_count} + {9'd0, side};
        if (step_reg)
            idx_reg <= {6'd0, t1_reg} * {12'd0, spt} + {8'd0, sector}
                       - fdc_pkg::IDX_W'(1);
    end

    assign idx  = idx_reg;
    assign done = done_reg;

    a_done_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> ##1 done) else $error("index unit latency");
endmodule

// File: hw/rtl/floppy_dma_controller_regs.sv
// ---------------------------------------------------------------------------
// floppy_dma_controller_regs
// Floppy controller behind a DMA register window, one bus access per item.
// ---------------------------------------------------------------------------
// s_ channel: one item per bus access, drive port write or tick. The block
// takes an item only when idle; s_ready drops until its last result is
// loaded into the output register.
// m_ channel: zero or more transfer/id items, then one item with last set.
// Plain accesses: the input item is registered, executed, and then its final
// item is loaded, so the next input item is taken only after that. A sector
// run goes, per sector, through a start state for the index unit, a wait
// state while it computes, and a check-and-issue state, until the run limit,
// the end of the track or the sector count ends it.
// When the receiver stalls, the block holds in its issue state until the
// output register frees; the output register lets the next result be
// prepared while the last one waits.
// Reset: registers take their reset values, drive port reads all ones, the
// sector register one, configuration its defaults. The user must write
// configuration via cfg_wr_en/cfg_index/cfg_wdata while idle; unchecked.
// ---------------------------------------------------------------------------
module floppy_dma_controller_regs #(
    parameter int SECTOR_BYTES          = fdc_pkg::SECTOR_BYTES_DEF,
    parameter int MAX_SECTORS_PER_TRACK = fdc_pkg::MAX_SPT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fdc_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fdc_pkg::out_item_t                m_data,
    input  logic                              cfg_wr_en,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fdc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    localparam int MW = $clog2(MAX_SECTORS_PER_TRACK + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_CALC, ST_WAIT, ST_CHECK, ST_IDREC, ST_FINAL
    } state_t;

    state_t              state_reg;
    fdc_pkg::in_item_t   item_reg;
    fdc_pkg::out_item_t  out_reg;
    logic                out_valid_reg;

    logic [7:0]  tracks_reg;
    logic [1:0]  sides_reg;
    logic [3:0]  spt_reg;
    logic        media_reg;
    logic [24:0] mem_reg;
    logic [15:0] irqdly_reg;

    logic [15:0] mode_reg;
    logic [23:0] addr_reg;
    logic [7:0]  count_reg, track_reg, sector_reg, data_reg, status_reg;
    logic        irq_reg, busy_reg, motor_reg, failed_reg, outward_reg;
    logic [15:0] delay_reg;
    logic [7:0]  drive_reg, lastcmd_reg;
    logic [15:0] rd_reg;
    logic [1:0]  kind_reg;
    logic [MW-1:0] moved_reg;

    logic                      idx_start, idx_done;
    logic [fdc_pkg::IDX_W-1:0] idx;
    logic                      side, out_free, ok, drive0;
    logic [25:0]               addr_end;
    logic [7:0]                cmd, sector_inc, st_v;
    logic [15:0]               dly_load;
    logic [MW-1:0]             moved_inc;

    assign side       = ~drive_reg[0];
    assign drive0     = ~drive_reg[1];
    assign out_free   = !out_valid_reg || m_ready;
    assign idx_start  = (state_reg == ST_CALC);
    assign addr_end   = {2'b0, addr_reg} + 26'(SECTOR_BYTES);
    assign cmd        = item_reg.value[7:0];
    assign sector_inc = sector_reg + 8'd1;
    assign moved_inc  = moved_reg + MW'(1);
    assign dly_load   = (irqdly_reg == 16'd0) ? 16'd1 : irqdly_reg;
    assign ok = (track_reg < tracks_reg) && ({1'b0, side} < sides_reg)
        && (sector_reg != 8'd0) && (sector_reg <= {4'd0, spt_reg})
        && (idx <= fdc_pkg::IDX_W'(2047)) && (mem_reg != 25'd0)
        && (addr_end <= {1'b0, mem_reg});

    always_comb begin
        st_v = status_reg;
        if (busy_reg) st_v[0] = 1'b1;
        if (!lastcmd_reg[7]) begin
            if (track_reg == 8'd0) st_v[2] = 1'b1;
            if (motor_reg) st_v[5] = 1'b1;
        end
        if (motor_reg) st_v[7] = 1'b1;
    end

    fdc_idx_unit u_idx (
        .aclk(aclk), .aresetn(aresetn), .start(idx_start),
        .track(track_reg), .side(side), .side_count(sides_reg), .spt(spt_reg),
        .sector(sector_reg), .idx(idx), .done(idx_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tracks_reg <= 8'd80; sides_reg <= 2'd2; spt_reg <= 4'd9;
            media_reg <= 1'b0; mem_reg <= '0; irqdly_reg <= 16'd8000;
            mode_reg <= '0; addr_reg <= '0; count_reg <= '0; track_reg <= '0;
            sector_reg <= 8'd1; data_reg <= '0; status_reg <= '0;
            irq_reg <= 1'b0; busy_reg <= 1'b0; motor_reg <= 1'b0;
            failed_reg <= 1'b0; outward_reg <= 1'b0; delay_reg <= '0;
            drive_reg <= 8'hff; lastcmd_reg <= '0;
            rd_reg <= '0; kind_reg <= '0; moved_reg <= '0;
        end else begin
            if (m_ready) out_valid_reg <= 1'b0;
            if (cfg_wr_en) begin
                case (cfg_index)
                    fdc_pkg::CFG_TRACKS:   tracks_reg <= cfg_wdata[7:0];
                    fdc_pkg::CFG_SIDES:    sides_reg  <= cfg_wdata[1:0];
                    fdc_pkg::CFG_SPT:      spt_reg    <= cfg_wdata[3:0];
                    fdc_pkg::CFG_MEDIA:    media_reg  <= cfg_wdata[0];
                    fdc_pkg::CFG_MEMBYTES: mem_reg    <= cfg_wdata;
                    fdc_pkg::CFG_IRQDLY:   irqdly_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    rd_reg <= '0;
                    state_reg <= ST_FINAL;
                    case (item_reg.op)
                        fdc_pkg::OP_WR_MODE: begin
                            if (mode_reg[8] != item_reg.value[8]) failed_reg <= 1'b0;
                            mode_reg <= item_reg.value;
                        end
                        fdc_pkg::OP_WR_ADDR: begin
                            case (item_reg.byte_select)
                                2'd0: addr_reg[23:16] <= item_reg.value[7:0];
                                2'd1: addr_reg[15:8]  <= item_reg.value[7:0];
                                default: addr_reg[7:0] <= item_reg.value[7:0];
                            endcase
                        end
                        fdc_pkg::OP_RD_ADDR: begin
                            case (item_reg.byte_select)
                                2'd0: rd_reg <= {8'd0, addr_reg[23:16]};
                                2'd1: rd_reg <= {8'd0, addr_reg[15:8]};
                                default: rd_reg <= {8'd0, addr_reg[7:0]};
                            endcase
                        end
                        fdc_pkg::OP_WR_DATA: begin
                            if (mode_reg[4]) begin
                                count_reg <= item_reg.value[7:0];
                            end else begin
                                case (mode_reg[2:1])
                                    2'd1: track_reg <= item_reg.value[7:0];
                                    2'd2: sector_reg <= item_reg.value[7:0];
                                    2'd3: data_reg <= item_reg.value[7:0];
                                    default: begin
                                        lastcmd_reg <= cmd;
                                        failed_reg <= 1'b0;
                                        status_reg <= '0;
                                        motor_reg <= 1'b1;
                                        busy_reg <= 1'b1;
                                        irq_reg <= 1'b0;
                                        delay_reg <= dly_load;
                                        if (!cmd[7]) begin
                                            if (cmd[7:4] == 4'h0) track_reg <= '0;
                                            else if (cmd[7:4] == 4'h1) track_reg <= data_reg;
                                            else begin
                                                if (cmd[6:5] == 2'b10) begin
                                                    outward_reg <= 1'b0;
                                                    if (track_reg < fdc_pkg::MAX_TRACK)
                                                        track_reg <= track_reg + 8'd1;
                                                end else if (cmd[6:5] == 2'b11) begin
                                                    outward_reg <= 1'b1;
                                                    if (track_reg != 8'd0)
                                                        track_reg <= track_reg - 8'd1;
                                                end else if (outward_reg) begin
                                                    if (track_reg != 8'd0)
                                                        track_reg <= track_reg - 8'd1;
                                                end else if (track_reg < fdc_pkg::MAX_TRACK) begin
                                                    track_reg <= track_reg + 8'd1;
                                                end
                                            end
                                        end else if (cmd[7:4] == 4'hd) begin
                                            busy_reg <= 1'b0;
                                            delay_reg <= '0;
                                            irq_reg <= cmd[3];
                                        end else if (cmd[7:6] == 2'b10) begin
                                            kind_reg <= cmd[5] ? fdc_pkg::KIND_WR
                                                               : fdc_pkg::KIND_RD;
                                            moved_reg <= '0;
                                            if (!drive0 || !media_reg) begin
                                                failed_reg <= 1'b1;
                                                status_reg <= fdc_pkg::STATUS_RNF;
                                            end else if (count_reg != 8'd0) begin
                                                state_reg <= ST_CALC;
                                            end
                                        end else if (cmd[7:4] == 4'hc) begin
                                            if (!drive0 || !media_reg) begin
                                                status_reg <= fdc_pkg::STATUS_RNF;
                                            end else begin
                                                data_reg <= track_reg;
                                                if (count_reg != 8'd0 && mem_reg != 25'd0
                                                    && ({1'b0, addr_reg} + 25'd6) <= mem_reg)
                                                    state_reg <= ST_IDREC;
                                            end
                                        end else if (cmd[7:4] != 4'he) begin
                                            status_reg <= fdc_pkg::STATUS_RNF;
                                        end
                                    end
                                endcase
                            end
                        end
                        fdc_pkg::OP_RD_DATA: begin
                            if (mode_reg[4]) begin
                                rd_reg <= {8'd0, count_reg};
                            end else begin
                                case (mode_reg[2:1])
                                    2'd1: rd_reg <= {8'd0, track_reg};
                                    2'd2: rd_reg <= {8'd0, sector_reg};
                                    2'd3: rd_reg <= {8'd0, data_reg};
                                    default: begin
                                        rd_reg <= {8'd0, st_v};
                                        irq_reg <= 1'b0;
                                    end
                                endcase
                            end
                        end
                        fdc_pkg::OP_RD_DMAST:
                            rd_reg <= {14'd0, count_reg == 8'd0, !failed_reg};
                        fdc_pkg::OP_WR_DRIVE: drive_reg <= item_reg.value[7:0];
                        default: begin
                            if (delay_reg != 16'd0) begin
                                if (item_reg.cycles >= delay_reg) begin
                                    delay_reg <= '0;
                                    busy_reg <= 1'b0;
                                    irq_reg <= 1'b1;
                                end else begin
                                    delay_reg <= delay_reg - item_reg.cycles;
                                end
                            end
                        end
                    endcase
                end
                ST_CALC: state_reg <= ST_WAIT;
                ST_WAIT: if (idx_done) state_reg <= ST_CHECK;
                ST_CHECK: begin
                    if (!ok) begin
                        failed_reg <= 1'b1;
                        status_reg <= fdc_pkg::STATUS_RNF;
                        state_reg <= ST_FINAL;
                    end else if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{kind: kind_reg, disk_sector_index: idx[10:0],
                            memory_address: addr_reg, id_record: '0, read_data: '0,
                            interrupt_line: 1'b0, busy_flag: 1'b1, last: 1'b0};
                        addr_reg <= addr_reg + 24'(SECTOR_BYTES);
                        count_reg <= count_reg - 8'd1;
                        moved_reg <= moved_inc;
                        if (sector_inc > {4'd0, spt_reg}) begin
                            sector_reg <= 8'd1;
                            state_reg <= ST_FINAL;
                        end else begin
                            sector_reg <= sector_inc;
                            if (count_reg == 8'd1
                                || moved_inc == MW'(MAX_SECTORS_PER_TRACK))
                                state_reg <= ST_FINAL;
                            else
                                state_reg <= ST_CALC;
                        end
                    end
                end
                ST_IDREC: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{kind: fdc_pkg::KIND_IDREC, disk_sector_index: '0,
                            memory_address: addr_reg,
                            id_record: {track_reg, 7'd0, side, sector_reg, 8'd2, 16'd0},
                            read_data: '0, interrupt_line: 1'b0, busy_flag: 1'b1,
                            last: 1'b0};
                        addr_reg <= addr_reg + 24'd6;
                        count_reg <= count_reg - 8'd1;
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{kind: fdc_pkg::KIND_ACK, disk_sector_index: '0,
                            memory_address: '0, id_record: '0, read_data: rd_reg,
                            interrupt_line: irq_reg, busy_flag: busy_reg, last: 1'b1};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_xfer_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (m_data.busy_flag && !m_data.interrupt_line))
        else $error("transfer item without busy");
    a_run_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        moved_reg <= MW'(MAX_SECTORS_PER_TRACK)) else $error("run limit exceeded");
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL && out_free) |=> (m_valid && m_data.last && s_ready))
        else $error("final item not issued");
endmodule
